>>> rtl/sdtq_pkg.sv
// Package with types and constants of the sorted deadline timer queue.
package sdtq_pkg;

	localparam int NumTimersDefault = 16;
	localparam int IdW = 4;
	localparam logic [62:0] TMax = {63{1'b1}};

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [IdW-1:0]     timer_id;
		logic signed [63:0] interval;
		logic               periodic;
		logic               deferred;
		logic [62:0]        now;
	} req_t;

	typedef struct packed {
		logic           kind;
		logic [IdW-1:0] expired_id;
		logic           expired_deferred;
		logic           device_enabled;
		logic           next_valid;
		logic [62:0]    next_delay;
		logic           last;
	} rsp_t;

	localparam logic KIND_EXPIRED = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

endpackage

>>> rtl/sdtq_ram.sv
// Synchronous memory with one write port and one registered read port.
module sdtq_ram #(
	parameter int Depth = 16,
	parameter int Width = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write and read in one clocked block; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue.
// Usage:
//   An input request (action, timer_id, interval, periodic, deferred, now) is
//   taken when in_valid is high and in_stall is low. A tick request returns
//   one expired report per due timer, soonest first, and then a status
//   result; start and stop requests return only the status result, marked by
//   last. The output channel holds out_valid until out_stall is low.
//   Deadlines and periods sit in two synchronous memories with a registered
//   read; the ordered list is a small register array of slot numbers.
// Request flow:
//   One request at a time. A start walks the list entry by entry (memory
//   read, then compare), plus the stop walk when it restarts an armed timer.
//   A tick removes the expired timers one by one; a periodic one is read
//   back for its period and re-inserted by its own walk. Stop walks the list
//   until it finds the timer. The memory read latency sets the step.
// Reset:
//   arst_n clears the list, the armed flags and the engine; the tick device
//   comes up enabled and one-shot. Memories are not cleared.
// Stall:
//   While out_stall is high the result is held; the engine waits only when it has a new result to give.
// Configuration:
//   cfg_valid/cfg_ready write device_periodic; ready is high when idle.
module sorted_deadline_timer_queue #(
	parameter int NUM_TIMERS = sdtq_pkg::NumTimersDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  sdtq_pkg::req_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output sdtq_pkg::rsp_t   out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);
	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_STOP_FIND, S_START, S_INS_RD, S_INS_CMP, S_INS_SHIFT,
		S_TICK_RD, S_TICK_CMP, S_TICK_EMIT, S_TICK_PER, S_STAT_RD, S_STATUS,
		S_WAIT
	} state_t;

	state_t           state_q, ret_q;
	sdtq_pkg::req_t   req_q;
	logic             dev_per_q;
	logic             tick_en_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    order_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] armed_q, per_q, def_q, done_q;
	logic [CW-1:0]    pos_q;
	logic [AW-1:0]    slot_q;
	logic [62:0]      new_dl_q;
	logic             nv_q;
	logic [62:0]      nd_q;
	logic             ins_mode_q; // 1 when insertion is from a start
	sdtq_pkg::rsp_t   out_q;
	logic             out_v_q;

	// Memory ports.
	logic             dl_we, pl_we;
	logic [AW-1:0]    dl_wa, dl_ra, pl_wa, pl_ra;
	logic [62:0]      dl_wd, dl_rd;
	logic [62:0]      pl_wd, pl_rd;

	sdtq_ram #(.Depth(NUM_TIMERS), .Width(63)) u_dl (
		.clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd),
		.raddr(dl_ra), .rdata(dl_rd));
	sdtq_ram #(.Depth(NUM_TIMERS), .Width(63)) u_pl (
		.clk(clk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd),
		.raddr(pl_ra), .rdata(pl_rd));

	logic [AW-1:0] id_a;
	logic          id_ok;
	logic          pos_len;
	logic [63:0]   sum_start, sum_per;
	logic [62:0]   sat_start, sat_per;
	logic [AW-1:0] head;
	logic [AW-1:0] rd_slot;
	logic          tick_en_idle;

	assign id_a    = req_q.timer_id[AW-1:0];
	assign id_ok   = ({28'd0, req_q.timer_id} < 32'(NUM_TIMERS));
	assign pos_len = (req_q.interval != 64'sd0) && !req_q.interval[63];
	assign sum_start = {1'b0, req_q.now} + {1'b0, req_q.interval[62:0]};
	assign sat_start = sum_start[63] ? sdtq_pkg::TMax : sum_start[62:0];
	assign sum_per   = {1'b0, req_q.now} + {1'b0, pl_rd};
	assign sat_per   = sum_per[63] ? sdtq_pkg::TMax : sum_per[62:0];
	assign head      = order_q[0];
	assign rd_slot   = order_q[pos_q[AW-1:0]];

	// Device enable as seen by a request taken together with a register write.
	assign tick_en_idle = cfg_valid ? (!cfg_data || (cnt_q != '0)) : tick_en_q;

	// Memory port control.
	always_comb begin
		dl_we = 1'b0;
		dl_wa = slot_q;
		dl_wd = new_dl_q;
		pl_we = 1'b0;
		pl_wa = id_a;
		pl_wd = req_q.interval[62:0];
		dl_ra = rd_slot;
		pl_ra = slot_q;
		case (state_q)
			S_START: begin
				pl_we = id_ok && pos_len && (req_q.action == sdtq_pkg::ACT_START);
			end
			S_INS_SHIFT: dl_we = 1'b1;
			S_TICK_RD, S_STAT_RD: dl_ra = head;
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	logic [62:0] delay_v;
	assign delay_v = (dl_rd > req_q.now) ? (dl_rd - req_q.now) : 63'd1;

	// Control state, list and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			req_q     <= '0;
			dev_per_q <= 1'b0;
			tick_en_q <= 1'b1;
			cnt_q     <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				order_q[i] <= '0;
			end
			armed_q   <= '0;
			per_q     <= '0;
			def_q     <= '0;
			done_q    <= '0;
			pos_q     <= '0;
			slot_q    <= '0;
			new_dl_q  <= '0;
			out_q     <= '0;
			out_v_q   <= 1'b0;
			nv_q      <= 1'b0;
			nd_q      <= '0;
			ins_mode_q <= 1'b0;
		end else begin
			if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						dev_per_q <= cfg_data;
						tick_en_q <= tick_en_idle;
					end
					if (in_valid) begin
						req_q  <= in_data;
						nv_q   <= 1'b0;
						nd_q   <= '0;
						pos_q  <= '0;
						done_q <= '0;
						slot_q <= in_data.timer_id[AW-1:0];
						case (in_data.action)
							sdtq_pkg::ACT_TICK: begin
								state_q <= tick_en_idle ? S_TICK_RD : S_STATUS;
							end
							sdtq_pkg::ACT_START, sdtq_pkg::ACT_STOP: state_q <= S_STOP_FIND;
							default: state_q <= S_STATUS;
						endcase
					end
				end
				// Stop phase: remove the timer from the list by shifting up.
				S_STOP_FIND: begin
					if (id_ok && armed_q[id_a] &&
						((req_q.action == sdtq_pkg::ACT_STOP) || pos_len)) begin
						if (order_q[pos_q[AW-1:0]] == id_a) begin
							for (int i = 0; i < NUM_TIMERS - 1; i++) begin
								if (CW'(i) >= pos_q) order_q[i] <= order_q[i+1];
							end
							cnt_q <= cnt_q - CW'(1);
							armed_q[id_a] <= 1'b0;
							if (!dev_per_q) begin
								if (pos_q == '0 && cnt_q > CW'(1)) begin
									nv_q <= 1'b1;
									ret_q <= S_START;
									state_q <= S_STAT_RD;
								end else begin
									state_q <= S_START;
								end
							end else begin
								if (cnt_q == CW'(1)) tick_en_q <= 1'b0;
								state_q <= S_START;
							end
						end else begin
							pos_q <= pos_q + CW'(1);
						end
					end else begin
						state_q <= S_START;
					end
				end
				// Start phase: record the slot and begin the ordered insertion.
				S_START: begin
					if (id_ok && pos_len && (req_q.action == sdtq_pkg::ACT_START)) begin
						per_q[id_a] <= req_q.periodic;
						def_q[id_a] <= req_q.deferred;
						slot_q      <= id_a;
						new_dl_q    <= sat_start;
						pos_q       <= '0;
						ins_mode_q  <= 1'b1;
						state_q     <= S_INS_RD;
					end else begin
						state_q <= S_STATUS;
					end
				end
				S_INS_RD: begin
					state_q <= (pos_q < cnt_q) ? S_INS_CMP : S_INS_SHIFT;
				end
				S_INS_CMP: begin
					if (dl_rd <= new_dl_q) begin
						pos_q <= pos_q + CW'(1);
						state_q <= S_INS_RD;
					end else begin
						state_q <= S_INS_SHIFT;
					end
				end
				// Open a hole at pos_q and place the slot there.
				S_INS_SHIFT: begin
					for (int i = 1; i < NUM_TIMERS; i++) begin
						if (CW'(i) > pos_q) order_q[i] <= order_q[i-1];
					end
					order_q[pos_q[AW-1:0]] <= slot_q;
					cnt_q <= cnt_q + CW'(1);
					armed_q[slot_q] <= 1'b1;
					if (ins_mode_q) begin
						if (!dev_per_q) begin
							if (pos_q == '0) begin
								nv_q <= 1'b1;
								nd_q <= (new_dl_q > req_q.now) ?
									(new_dl_q - req_q.now) : 63'd1;
							end
						end else begin
							tick_en_q <= 1'b1;
						end
						state_q <= S_STATUS;
					end else begin
						pos_q <= '0;
						state_q <= S_TICK_RD;
					end
				end
				// Tick: read the head deadline and check for expiry.
				S_TICK_RD: begin
					state_q <= (cnt_q != '0) ? S_TICK_CMP : S_TICK_PER;
					if (cnt_q == '0) ret_q <= S_IDLE;
				end
				S_TICK_CMP: begin
					if (done_q[head] || (req_q.now < dl_rd)) begin
						ret_q   <= S_IDLE;
						state_q <= S_TICK_PER;
					end else begin
						slot_q <= head;
						done_q[head] <= 1'b1;
						for (int i = 0; i < NUM_TIMERS - 1; i++) begin
							order_q[i] <= order_q[i+1];
						end
						cnt_q <= cnt_q - CW'(1);
						armed_q[head] <= 1'b0;
						state_q <= S_TICK_EMIT;
					end
				end
				S_TICK_EMIT: begin
					if (!out_v_q || !out_stall) begin
						out_v_q <= 1'b1;
						out_q   <= '{kind: sdtq_pkg::KIND_EXPIRED, expired_id:
							sdtq_pkg::IdW'(slot_q), expired_deferred: def_q[slot_q],
							device_enabled: 1'b0, next_valid: 1'b0,
							next_delay: '0, last: 1'b0};
						if (per_q[slot_q]) begin
							state_q <= S_WAIT;
							ret_q   <= S_TICK_PER;
						end else begin
							state_q <= S_TICK_RD;
						end
					end
				end
				S_WAIT: begin
					// Period memory read for slot_q lands this cycle.
					new_dl_q <= sat_per;
					ins_mode_q <= 1'b0;
					pos_q <= '0;
					state_q <= S_INS_RD;
				end
				// End of tick walk: work out device state and delay.
				S_TICK_PER: begin
					if (!dev_per_q) begin
						if (cnt_q != '0) begin
							nv_q <= 1'b1;
							ret_q <= S_STATUS;
							state_q <= S_STAT_RD;
						end else begin
							state_q <= S_STATUS;
						end
					end else begin
						if (cnt_q == '0) tick_en_q <= 1'b0;
						state_q <= S_STATUS;
					end
				end
				S_STAT_RD: begin
					// The head is the read address in this state; its deadline is valid in S_WAIT.
					state_q <= S_WAIT;
					ret_q   <= ret_q;
				end
				S_STATUS: begin
					if (!out_v_q || !out_stall) begin
						out_v_q <= 1'b1;
						out_q   <= '{kind: sdtq_pkg::KIND_STATUS, expired_id: '0,
							expired_deferred: 1'b0, device_enabled: tick_en_q,
							next_valid: nv_q, next_delay: nv_q ? nd_q : '0,
							last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// Delay capture after a head read (S_STAT_RD then S_WAIT).
			if (state_q == S_WAIT && ret_q != S_TICK_PER) begin
				nd_q    <= delay_v;
				state_q <= ret_q;
			end
		end
	end
endmodule

>>> rtl/sdtq_checker.sv
// Port-level checker for the sorted deadline timer queue, bound to the top.
module sdtq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input sdtq_pkg::rsp_t out_data,
	input logic           cfg_ready
);
	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The status result carries last and no report fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == sdtq_pkg::KIND_STATUS |->
		out_data.last && out_data.expired_id == '0)
		else $error("bad status result");

	// A report is never marked last.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == sdtq_pkg::KIND_EXPIRED |-> !out_data.last)
		else $error("report marked last");

	// A requested delay is at least one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.next_valid |-> out_data.next_delay != '0)
		else $error("zero delay");

	// Configuration is taken only while requests are taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !in_stall)
		else $error("config ready while busy");
endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
	.cfg_ready(cfg_ready)
);

>>> tb/sv/tb_top.sv
// Testbench of the sorted deadline timer queue: directed table, random requests, checked results.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NT = 16;
	localparam int WatchLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sdtq_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sdtq_pkg::rsp_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	sorted_deadline_timer_queue #(.NUM_TIMERS(NT)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the timer queue state.
	logic        dev_periodic;
	logic [63:0] dl [NT];
	logic [63:0] plen [NT];
	logic        is_per [NT];
	logic        is_def [NT];
	logic        arm [NT];
	int          order [$];
	logic        tick_en;

	sdtq_pkg::rsp_t expected_rsp [$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int idle_cycles = 0;

	function automatic logic [62:0] delay_of(int s, logic [62:0] now);
		return (dl[s] > {1'b0, now}) ? 63'(dl[s] - {1'b0, now}) : 63'd1;
	endfunction

	function automatic logic [63:0] sat_add(logic [62:0] a, logic [63:0] b);
		logic [63:0] s;
		s = {1'b0, a} + b;
		return (s > {1'b0, sdtq_pkg::TMax}) ? {1'b0, sdtq_pkg::TMax} : s;
	endfunction

	function automatic void list_insert(int s);
		int p;
		p = 0;
		while (p < order.size() && dl[order[p]] <= dl[s]) p++;
		order.insert(p, s);
		arm[s] = 1'b1;
	endfunction

	function automatic int unlink_timer(int s);
		for (int p = 0; p < order.size(); p++) begin
			if (order[p] == s) begin
				order.delete(p);
				arm[s] = 1'b0;
				return p;
			end
		end
		return order.size();
	endfunction

	function automatic sdtq_pkg::rsp_t report(int s, logic d);
		sdtq_pkg::rsp_t r;
		r = '0;
		r.kind = sdtq_pkg::KIND_EXPIRED;
		r.expired_id = sdtq_pkg::IdW'(s);
		r.expired_deferred = d;
		return r;
	endfunction

	// Works out the results of one request and queues them.
	function automatic void predict_timers(sdtq_pkg::req_t q);
		logic nv;
		logic [62:0] nd;
		logic done [NT];
		logic pos_len, do_stop;
		int s, pos, id;
		sdtq_pkg::rsp_t st;
		nv = 1'b0; nd = '0;
		id = int'(q.timer_id);
		for (int i = 0; i < NT; i++) done[i] = 1'b0;
		if (q.action == sdtq_pkg::ACT_TICK) begin
			if (tick_en) begin
				while (order.size() > 0) begin
					s = order[0];
					if (done[s] || {1'b0, q.now} < dl[s]) break;
					done[s] = 1'b1;
					void'(unlink_timer(s));
					expected_rsp.push_back(report(s, is_def[s]));
					if (is_per[s]) begin
						dl[s] = sat_add(q.now, plen[s]);
						list_insert(s);
					end
				end
				if (!dev_periodic) begin
					if (order.size() > 0) begin
						nv = 1'b1; nd = delay_of(order[0], q.now);
					end
				end else if (order.size() == 0) tick_en = 1'b0;
			end
		end else if (q.action == sdtq_pkg::ACT_START || q.action == sdtq_pkg::ACT_STOP) begin
			pos_len = q.interval > 0;
			do_stop = (q.action == sdtq_pkg::ACT_STOP) || pos_len;
			if (id < NT && do_stop && arm[id]) begin
				pos = unlink_timer(id);
				if (!dev_periodic) begin
					if (pos == 0 && order.size() > 0) begin
						nv = 1'b1; nd = delay_of(order[0], q.now);
					end
				end else if (order.size() == 0) tick_en = 1'b0;
			end
			if (id < NT && q.action == sdtq_pkg::ACT_START && pos_len) begin
				is_per[id] = q.periodic;
				is_def[id] = q.deferred;
				plen[id] = q.interval;
				dl[id] = sat_add(q.now, q.interval);
				list_insert(id);
				if (!dev_periodic) begin
					if (order[0] == id) begin
						nv = 1'b1; nd = delay_of(id, q.now);
					end
				end else tick_en = 1'b1;
			end
		end
		st = '0;
		st.kind = sdtq_pkg::KIND_STATUS;
		st.device_enabled = tick_en;
		st.next_valid = nv;
		st.next_delay = nd;
		st.last = 1'b1;
		expected_rsp.push_back(st);
	endfunction

	// Output side: random stall, compare accepted results.
	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		sdtq_pkg::rsp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected result %p", out_data);
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (out_data.kind !== e.kind) begin
					$error("kind exp %0d got %0d", e.kind, out_data.kind); errors++;
				end
				if (out_data.expired_id !== e.expired_id) begin
					$error("expired_id exp %0d got %0d", e.expired_id, out_data.expired_id);
					errors++;
				end
				if (out_data.expired_deferred !== e.expired_deferred) begin
					$error("expired_deferred exp %0d got %0d", e.expired_deferred,
						out_data.expired_deferred);
					errors++;
				end
				if (out_data.device_enabled !== e.device_enabled) begin
					$error("device_enabled exp %0d got %0d", e.device_enabled,
						out_data.device_enabled);
					errors++;
				end
				if (out_data.next_valid !== e.next_valid) begin
					$error("next_valid exp %0d got %0d", e.next_valid, out_data.next_valid);
					errors++;
				end
				if (out_data.next_delay !== e.next_delay) begin
					$error("next_delay exp %0d got %0d", e.next_delay, out_data.next_delay);
					errors++;
				end
				if (out_data.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, out_data.last); errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no accepted request or result.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Sends one request, with random idle gaps before it.
	task automatic send_req(sdtq_pkg::req_t q);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_timers(q);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_device(logic v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		dev_periodic = v;
		tick_en = v ? (order.size() != 0) : 1'b1;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic sdtq_pkg::req_t mk(logic [1:0] a, int id, logic [63:0] iv, logic p,
		logic d, logic [62:0] now);
		sdtq_pkg::req_t q;
		q.action = a; q.timer_id = sdtq_pkg::IdW'(id); q.interval = iv;
		q.periodic = p; q.deferred = d; q.now = now;
		return q;
	endfunction

	// Random request; mostly starts and ticks with a slowly rising clock.
	function automatic sdtq_pkg::req_t rand_req(ref logic [62:0] clock_ns);
		sdtq_pkg::req_t q;
		int r;
		r = $urandom_range(99);
		clock_ns = clock_ns + 63'($urandom_range(40));
		q = mk(sdtq_pkg::ACT_TICK, int'($urandom_range(NT - 1)),
			64'($urandom_range(1, 60)), 1'($urandom_range(1)), 1'($urandom_range(1)),
			clock_ns);
		if (r < 40) q.action = sdtq_pkg::ACT_START;
		else if (r < 55) q.action = sdtq_pkg::ACT_STOP;
		else if (r < 60) q.action = sdtq_pkg::ACT_NONE;
		if (r >= 90) begin
			q.interval = {$urandom, $urandom};
			q.now = 63'({$urandom, $urandom});
			q.action = sdtq_pkg::ACT_START;
		end else if (r >= 86) q.interval = 64'(-$signed(64'($urandom_range(3))));
		return q;
	endfunction

	typedef struct {
		sdtq_pkg::req_t q;
		logic chk;
		sdtq_pkg::rsp_t r;
	} row_t;

	initial begin
		row_t rows [$];
		row_t w;
		sdtq_pkg::rsp_t st0;
		logic [62:0] clock_ns;
		int phase;
		dev_periodic = 1'b0; tick_en = 1'b1;
		for (int i = 0; i < NT; i++) begin
			arm[i] = 1'b0; is_per[i] = 1'b0; is_def[i] = 1'b0; dl[i] = '0; plen[i] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table.
		st0 = '0; st0.kind = sdtq_pkg::KIND_STATUS; st0.device_enabled = 1'b1;
		st0.last = 1'b1;
		w.chk = 1'b1; w.r = st0;
		w.q = mk(sdtq_pkg::ACT_TICK, 0, 0, 0, 0, 0); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_STOP, 15, 0, 0, 0, 5); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_NONE, 3, 10, 1, 1, 5); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_START, 2, 0, 1, 1, 5); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_START, 2, 64'h8000_0000_0000_0000, 1, 1, 5); rows.push_back(w);
		w.chk = 1'b0;
		w.q = mk(sdtq_pkg::ACT_START, 0, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1, sdtq_pkg::TMax);
		rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_START, 1, 100, 1, 0, 10); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_START, 2, 100, 0, 1, 10); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_START, 3, 50, 0, 0, 20); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_START, 1, 30, 1, 1, 20); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_STOP, 3, 0, 0, 0, 25); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_STOP, 3, 0, 0, 0, 25); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_TICK, 0, 0, 0, 0, 60); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_TICK, 0, 0, 0, 0, 200); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_START, 4, 1, 1, 0, 200); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_TICK, 0, 0, 0, 0, sdtq_pkg::TMax); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_STOP, 0, 0, 0, 0, 0); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_STOP, 1, 0, 0, 0, 0); rows.push_back(w);
		w.q = mk(sdtq_pkg::ACT_STOP, 4, 0, 0, 0, 0); rows.push_back(w);
		foreach (rows[i]) begin
			send_req(rows[i].q);
			if (rows[i].chk && expected_rsp[expected_rsp.size() - 1] !== rows[i].r) begin
				$error("row %0d status exp %p", i, rows[i].r);
				errors++;
			end
		end

		// Random part over idling phases and both device types.
		clock_ns = 0;
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle = 0; recv_idle = 0; end
				1: begin send_idle = 51; recv_idle = 0; end
				2: begin send_idle = 0; recv_idle = 51; end
				default: begin send_idle = 32; recv_idle = 32; end
			endcase
			write_device(phase[0] ^ phase[2]);
			for (int k = 0; k < 14; k++) send_req(rand_req(clock_ns));
			if (phase == 3) drain();
		end
		write_device(1'b0);
		recv_idle = 0;

		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

>>> files.f
rtl/sdtq_pkg.sv
rtl/sdtq_ram.sv
rtl/sorted_deadline_timer_queue.sv
rtl/sdtq_checker.sv
tb/sv/tb_top.sv
